[src/skt_pkg.sv]
// Package: shared types, codes and defaults for the sorted key table.
`default_nettype none

package skt_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 32;
	localparam int PAY_W        = 32;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [5:0]       position;
		logic [PAY_W-1:0] found_payload;
		logic [6:0]       entry_count;
	} rsp_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
	} rec_t;

endpackage

`default_nettype wire

[src/skt_mem.sv]
// Record memory: one write port, one registered read port.
`default_nettype none

module skt_mem #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output skt_pkg::rec_t      rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire skt_pkg::rec_t wr_data
);

	skt_pkg::rec_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[src/skt_core.sv]
// Sequencer: insert by shifting from the top, binary search, clear.
`default_nettype none

module skt_core #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire skt_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_ready,
	output skt_pkg::rsp_t      res,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  wire skt_pkg::rec_t rd_data,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output skt_pkg::rec_t      wr_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_INS0 = 3'd2;
	localparam logic [2:0] S_SRD  = 3'd3;
	localparam logic [2:0] S_SCMP = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	skt_pkg::rec_t new_q, new_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] lo_q, lo_d, hend_q, hend_d;
	logic [AW-1:0] mid_q, mid_d;
	skt_pkg::rsp_t res_q, res_d;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] lo_n, hend_n;
	logic [AW-1:0] ptr_up;

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;
	assign ptr_up    = ptr_q + AW'(1);
	assign mid_sum   = (CW+1)'(lo_q) + (CW+1)'(hend_q) - (CW+1)'(1);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		new_d   = new_q;
		ptr_d   = ptr_q;
		lo_d    = lo_q;
		hend_d  = hend_q;
		mid_d   = mid_q;
		res_d   = res_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = new_q;
		lo_n    = lo_q;
		hend_n  = hend_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					new_d.key     = req.key;
					new_d.payload = req.payload;
					res_d.status        = skt_pkg::ST_OK;
					res_d.position      = '0;
					res_d.found_payload = '0;
					res_d.entry_count   = 7'(count_q);
					state_d = S_RESP;
					case (req.mode)
						skt_pkg::MODE_INSERT: begin
							if (count_q == CW'(CAPACITY)) begin
								res_d.status = skt_pkg::ST_FULL;
							end else if (count_q == '0) begin
								wr_en   = 1'b1;
								wr_data.key     = req.key;
								wr_data.payload = req.payload;
								count_d = CW'(1);
								res_d.entry_count = 7'd1;
							end else begin
								ptr_d   = AW'(count_q - CW'(1));
								rd_en   = 1'b1;
								rd_addr = AW'(count_q - CW'(1));
								state_d = S_INS;
							end
						end
						skt_pkg::MODE_SEARCH: begin
							if (count_q == '0) begin
								res_d.status = skt_pkg::ST_MISSING;
							end else begin
								lo_d    = '0;
								hend_d  = count_q;
								state_d = S_SRD;
							end
						end
						skt_pkg::MODE_CLEAR: begin
							count_d = '0;
							res_d.entry_count = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = ptr_up;
				if ($signed(new_q.key) < $signed(rd_data.key)) begin
					wr_data = rd_data;
					if (ptr_q == '0) begin
						state_d = S_INS0;
					end else begin
						ptr_d   = ptr_q - AW'(1);
						rd_en   = 1'b1;
						rd_addr = ptr_q - AW'(1);
					end
				end else begin
					count_d = count_q + CW'(1);
					res_d.position    = 6'(ptr_up);
					res_d.entry_count = 7'(count_q + CW'(1));
					state_d = S_RESP;
				end
			end
			S_INS0: begin
				wr_en   = 1'b1;
				count_d = count_q + CW'(1);
				res_d.position    = '0;
				res_d.entry_count = 7'(count_q + CW'(1));
				state_d = S_RESP;
			end
			S_SRD: begin
				mid_d   = AW'(mid_sum >> 1);
				rd_en   = 1'b1;
				rd_addr = AW'(mid_sum >> 1);
				state_d = S_SCMP;
			end
			S_SCMP: begin
				if (rd_data.key == new_q.key) begin
					res_d.position      = 6'(mid_q);
					res_d.found_payload = rd_data.payload;
					state_d = S_RESP;
				end else begin
					if ($signed(rd_data.key) < $signed(new_q.key)) begin
						lo_n = CW'(mid_q) + CW'(1);
					end else begin
						hend_n = CW'(mid_q);
					end
					lo_d   = lo_n;
					hend_d = hend_n;
					if (lo_n < hend_n) begin
						state_d = S_SRD;
					end else begin
						res_d.status = skt_pkg::ST_MISSING;
						state_d = S_RESP;
					end
				end
			end
			S_RESP: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		new_q  <= new_d;
		ptr_q  <= ptr_d;
		lo_q   <= lo_d;
		hend_q <= hend_d;
		mid_q  <= mid_d;
		res_q  <= res_d;
	end

endmodule

`default_nettype wire

[src/sorted_key_table_with_search.sv]
// Top level: sorted key table with binary search, response register.
// Insert shifts each record with a greater key up one slot, one shift per cycle, then writes
// the new record; into an empty table it is written directly. Search takes one read and one
// compare per probe. Clear, full insert and unused mode respond without touching memory.
// One request in flight: req_ready returns in the same cycle that rsp_valid rises for the last one.
// Reset empties the table (count to zero); memory contents are not cleared.
`default_nettype none

module sorted_key_table_with_search #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire skt_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output skt_pkg::rsp_t      rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic          res_valid, res_ready;
	skt_pkg::rsp_t res;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	skt_pkg::rec_t rd_data, wr_data;
	logic          rsp_valid_q;
	skt_pkg::rsp_t rsp_q;

	skt_core #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	skt_mem #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

endmodule

`default_nettype wire

[dv/tb_sorted_key_table_with_search.sv]
// Testbench: random and directed insert, search, clear and unused-mode requests against a model of the table.
`timescale 1ns / 1ps

module tb_sorted_key_table_with_search;

	localparam int CAPACITY = skt_pkg::CAPACITY_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 150;
	localparam int HOLD_CYCLES = 250;
	localparam int HOLD_AT = 300;
	localparam int QUIET_FROM = 700;
	localparam int QUIET_TO = 1000;
	localparam int N_ITEMS = 1850;
	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam logic signed [skt_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
	localparam logic signed [skt_pkg::KEY_W-1:0] KEY_MIN = 32'sh80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	skt_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	skt_pkg::rsp_t rsp;

	sorted_key_table_with_search #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	skt_pkg::req_t pending[$];
	skt_pkg::rsp_t expected_rsp[$];

	logic signed [skt_pkg::KEY_W-1:0] key_tbl[CAPACITY];
	logic [skt_pkg::PAY_W-1:0] pay_tbl[CAPACITY];
	int held_n = 0;

	int n_req = 0;
	int n_bad = 0;
	int stall_cnt = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	logic req_took = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic skt_pkg::rsp_t table_apply(skt_pkg::req_t r);
		skt_pkg::rsp_t o;
		int slot;
		int lo;
		int hi;
		int mid;
		logic hit;
		o = '0;
		case (r.mode)
			skt_pkg::MODE_INSERT: begin
				if (held_n >= CAPACITY) begin
					o.status = skt_pkg::ST_FULL;
				end else begin
					slot = held_n;
					while (slot > 0 && r.key < key_tbl[slot-1]) begin
						key_tbl[slot] = key_tbl[slot-1];
						pay_tbl[slot] = pay_tbl[slot-1];
						slot--;
					end
					key_tbl[slot] = r.key;
					pay_tbl[slot] = r.payload;
					held_n++;
					o.position = slot[5:0];
				end
			end
			skt_pkg::MODE_SEARCH: begin
				o.status = skt_pkg::ST_MISSING;
				lo = 0;
				hi = held_n - 1;
				hit = 1'b0;
				while (lo <= hi && !hit) begin
					mid = (lo + hi) / 2;
					if (key_tbl[mid] == r.key) begin
						hit = 1'b1;
						o.status = skt_pkg::ST_OK;
						o.position = mid[5:0];
						o.found_payload = pay_tbl[mid];
					end else if (key_tbl[mid] < r.key) begin
						lo = mid + 1;
					end else begin
						hi = mid - 1;
					end
				end
			end
			skt_pkg::MODE_CLEAR: begin
				held_n = 0;
			end
			default: begin
			end
		endcase
		o.entry_count = held_n[6:0];
		return o;
	endfunction

	function automatic logic signed [skt_pkg::KEY_W-1:0] pick_key();
		logic signed [skt_pkg::KEY_W-1:0] k;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: k = $signed($urandom_range(15)) - 8;
			5: begin
				case ($urandom_range(5))
					0: k = KEY_MIN;
					1: k = KEY_MAX;
					2: k = 0;
					3: k = -1;
					4: k = KEY_MIN + 1;
					default: k = KEY_MAX - 1;
				endcase
			end
			default: k = $urandom;
		endcase
		return k;
	endfunction

	task automatic add_req(logic [1:0] m, logic signed [skt_pkg::KEY_W-1:0] k,
		logic [skt_pkg::PAY_W-1:0] p);
		skt_pkg::req_t r;
		r.mode = m;
		r.key = k;
		r.payload = p;
		pending.push_back(r);
	endtask

	function automatic logic quiet();
		return n_req >= QUIET_FROM && n_req < QUIET_TO;
	endfunction

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_took)) begin
			if (pending.size() != 0 && (quiet() || $urandom_range(99) >= 11)) begin
				req <= pending.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response receiver, with one long hold-off to back the table up
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_req >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= quiet() || $urandom_range(99) >= 11;
		end
	end

	// monitor
	always @(posedge clk) begin
		skt_pkg::rsp_t want;
		req_took <= req_valid && req_ready;
		if (req_valid && req_ready) begin
			expected_rsp.push_back(table_apply(req));
			n_req <= n_req + 1;
		end
		if (rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				if (n_bad < 10)
					$display("unexpected response: st %0d pos %0d pay %h cnt %0d",
						rsp.status, rsp.position, rsp.found_payload, rsp.entry_count);
				n_bad++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status || rsp.position !== want.position ||
					rsp.found_payload !== want.found_payload ||
					rsp.entry_count !== want.entry_count) begin
					if (n_bad < 10)
						$display("mismatch: want %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
							want.status, want.position, want.found_payload,
							want.entry_count, rsp.status, rsp.position,
							rsp.found_payload, rsp.entry_count);
					n_bad++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("watchdog: no request or response accepted for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		logic signed [skt_pkg::KEY_W-1:0] held_keys[$];
		logic signed [skt_pkg::KEY_W-1:0] k;
		int target;
		int n_ins;
		int pick;

		// directed
		add_req(skt_pkg::MODE_SEARCH, 0, $urandom);
		add_req(MODE_NOP, 5, $urandom);
		add_req(skt_pkg::MODE_INSERT, 0, '0);
		add_req(skt_pkg::MODE_INSERT, KEY_MAX, '1);
		add_req(skt_pkg::MODE_INSERT, KEY_MIN, 32'h0000_0001);
		add_req(skt_pkg::MODE_INSERT, 0, 32'hA5A5_A5A5);
		add_req(skt_pkg::MODE_INSERT, -1, $urandom);
		add_req(skt_pkg::MODE_INSERT, 0, 32'h5A5A_5A5A);
		add_req(skt_pkg::MODE_INSERT, 1, $urandom);
		add_req(skt_pkg::MODE_SEARCH, 0, $urandom);
		add_req(skt_pkg::MODE_SEARCH, KEY_MIN, $urandom);
		add_req(skt_pkg::MODE_SEARCH, KEY_MAX, $urandom);
		add_req(skt_pkg::MODE_SEARCH, -1, $urandom);
		add_req(skt_pkg::MODE_SEARCH, 2, $urandom);
		add_req(skt_pkg::MODE_SEARCH, -2, $urandom);
		add_req(MODE_NOP, KEY_MIN, '1);
		add_req(skt_pkg::MODE_CLEAR, 0, '0);
		add_req(skt_pkg::MODE_SEARCH, 0, $urandom);
		add_req(skt_pkg::MODE_CLEAR, KEY_MAX, '1);
		add_req(skt_pkg::MODE_INSERT, KEY_MAX, $urandom);
		add_req(skt_pkg::MODE_SEARCH, KEY_MAX, $urandom);
		add_req(skt_pkg::MODE_CLEAR, 0, '0);

		// random: fill episodes, mostly small, some past full, then usually clear
		while (pending.size() < N_ITEMS) begin
			target = ($urandom_range(4) == 0) ? CAPACITY + $urandom_range(1, 4)
				: $urandom_range(1, 24);
			n_ins = 0;
			while (n_ins < target && pending.size() < N_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					k = pick_key();
					add_req(skt_pkg::MODE_INSERT, k, $urandom);
					if (held_keys.size() < CAPACITY)
						held_keys.push_back(k);
					n_ins++;
				end else if (pick < 92) begin
					if (held_keys.size() != 0 && $urandom_range(2) != 0)
						k = held_keys[$urandom_range(held_keys.size() - 1)];
					else
						k = pick_key();
					add_req(skt_pkg::MODE_SEARCH, k, $urandom);
				end else if (pick < 95) begin
					add_req(MODE_NOP, $urandom, $urandom);
				end else begin
					add_req(skt_pkg::MODE_CLEAR, $urandom, $urandom);
					held_keys.delete();
				end
			end
			if ($urandom_range(4) != 0) begin
				add_req(skt_pkg::MODE_CLEAR, $urandom, $urandom);
				held_keys.delete();
			end
		end

		while (pending.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_bad == 0 && expected_rsp.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
